[rtl/core/assert_macros.svh]
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RPE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define RPE_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `RPE_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

[rtl/core/rpe_pkg.sv]
// package with frame offsets, constants and word types of the rtp payload extractor
package rpe_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [6:0] ETH_TYPE_HI_POS  = 7'd12;
  localparam logic [6:0] ETH_TYPE_LO_POS  = 7'd13;
  localparam logic [6:0] IP_PROTO_POS     = 7'd23;
  localparam logic [6:0] UDP_LEN_HI_POS   = 7'd38;
  localparam logic [6:0] UDP_LEN_LO_POS   = 7'd39;
  localparam logic [6:0] RTP_FIRST_POS    = 7'd42;
  localparam logic [6:0] PAYLOAD_BASE_POS = 7'd54;
  localparam logic [6:0] OFFSET_MAX       = 7'd127;

  localparam logic [7:0] ETH_TYPE_HI   = 8'h08;
  localparam logic [7:0] ETH_TYPE_LO   = 8'h00;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [7:0] VERSION_MASK  = 8'hc0;
  localparam logic [7:0] VERSION_TWO   = 8'h80;
  localparam logic [7:0] COUNT_MASK    = 8'h0f;
  localparam logic [15:0] HDR_FIXED_BYTES = 16'd20;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_payload;
    logic       truncated;
  } rpe_word_t;

  typedef struct packed {
    logic      valid;
    rpe_word_t word;
  } rpe_push_t;

endpackage

[rtl/core/rpe_parser.sv]
// front part: takes frame bytes, checks headers and picks out payload words
module rpe_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_frame_byte,
  input  logic             in_end_of_frame,
  input  logic             queue_full,
  output rpe_pkg::rpe_push_t push
);
  import rpe_pkg::*;

  logic [6:0]  byte_offset_r, byte_offset_nxt;
  logic        frame_accepted_r, frame_accepted_nxt;
  logic [15:0] udp_length_r, udp_length_nxt;
  logic [3:0]  csrc_count_r, csrc_count_nxt;
  logic [15:0] payload_left_r, payload_left_nxt;

  logic        accept;
  logic [3:0]  new_count;
  logic [15:0] hdr_len;
  logic [6:0]  payload_start;

  assign in_stall      = queue_full;
  assign accept        = in_valid & ~queue_full;
  assign new_count     = in_frame_byte[3:0] & COUNT_MASK[3:0];
  assign hdr_len       = HDR_FIXED_BYTES + {10'd0, new_count, 2'b00};
  assign payload_start = PAYLOAD_BASE_POS + {1'b0, csrc_count_r, 2'b00};

  always_comb begin
    byte_offset_nxt    = byte_offset_r;
    frame_accepted_nxt = frame_accepted_r;
    udp_length_nxt     = udp_length_r;
    csrc_count_nxt     = csrc_count_r;
    payload_left_nxt   = payload_left_r;
    push               = '0;
    push.word.payload_byte = in_frame_byte;
    if (accept) begin
      if (frame_accepted_r) begin
        priority if (byte_offset_r == ETH_TYPE_HI_POS) begin
          if (in_frame_byte != ETH_TYPE_HI) frame_accepted_nxt = 1'b0;
        end else if (byte_offset_r == ETH_TYPE_LO_POS) begin
          if (in_frame_byte != ETH_TYPE_LO) frame_accepted_nxt = 1'b0;
        end else if (byte_offset_r == IP_PROTO_POS) begin
          if (in_frame_byte != PROTO_UDP) frame_accepted_nxt = 1'b0;
        end else if (byte_offset_r == UDP_LEN_HI_POS) begin
          udp_length_nxt = {in_frame_byte, 8'd0};
        end else if (byte_offset_r == UDP_LEN_LO_POS) begin
          udp_length_nxt = {udp_length_r[15:8], in_frame_byte};
        end else if (byte_offset_r == RTP_FIRST_POS) begin
          if ((in_frame_byte & VERSION_MASK) != VERSION_TWO) begin
            frame_accepted_nxt = 1'b0;
          end else begin
            csrc_count_nxt = new_count;
            if (udp_length_r <= hdr_len) begin
              frame_accepted_nxt = 1'b0;
            end else begin
              payload_left_nxt = udp_length_r - hdr_len;
            end
          end
        end else if (byte_offset_r > RTP_FIRST_POS && byte_offset_r >= payload_start &&
                     payload_left_r != 16'd0) begin
          payload_left_nxt          = payload_left_r - 16'd1;
          push.valid                = 1'b1;
          push.word.last_of_payload = (payload_left_r == 16'd1) | in_end_of_frame;
          push.word.truncated       = in_end_of_frame & (payload_left_r != 16'd1);
        end else begin
          frame_accepted_nxt = frame_accepted_r;
        end
      end
      if (in_end_of_frame) begin
        byte_offset_nxt    = '0;
        frame_accepted_nxt = 1'b1;
        udp_length_nxt     = '0;
        csrc_count_nxt     = '0;
        payload_left_nxt   = '0;
      end else if (byte_offset_r != OFFSET_MAX) begin
        byte_offset_nxt = byte_offset_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r    <= '0;
      frame_accepted_r <= 1'b1;
      udp_length_r     <= '0;
      csrc_count_r     <= '0;
      payload_left_r   <= '0;
    end else begin
      byte_offset_r    <= byte_offset_nxt;
      frame_accepted_r <= frame_accepted_nxt;
      udp_length_r     <= udp_length_nxt;
      csrc_count_r     <= csrc_count_nxt;
      payload_left_r   <= payload_left_nxt;
    end
  end

endmodule

[rtl/core/rpe_queue.sv]
// back part: short word queue that drives the result channel
module rpe_queue #(
  parameter int unsigned DEPTH = rpe_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rpe_pkg::rpe_push_t push,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_payload_byte,
  output logic               out_last_of_payload,
  output logic               out_truncated
);
  import rpe_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rpe_word_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;
  rpe_word_t        head;

  assign full      = (count_r == CNT_FULL);
  assign out_valid = (count_r != '0);
  assign pop       = out_valid & ~out_stall;
  assign head      = mem_r[rd_ptr_r];

  assign out_payload_byte    = head.payload_byte;
  assign out_last_of_payload = head.last_of_payload;
  assign out_truncated       = head.truncated;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    if (pop)        rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    unique case ({push.valid, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.word;
  end

endmodule

[rtl/core/rtp_payload_extractor.sv]
// top level of the rtp payload extractor: header parser feeding a word queue
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    in_frame_byte, in_end_of_frame
//   out_     output     out_valid/out_stall  out_payload_byte, out_last_of_payload,
//                                            out_truncated
//
// one input word per cycle unless stalled; payload words are registered in the queue
// the parser updates its header counters in the cycle a byte is taken
// reset is synchronous and empties the queue; the next byte starts a frame
// in_stall rises only while the QUEUE_DEPTH-word queue is full from out_stall
module rtp_payload_extractor #(
  parameter int unsigned QUEUE_DEPTH = rpe_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_frame_byte,
  input  logic       in_end_of_frame,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_last_of_payload,
  output logic       out_truncated
);
  import rpe_pkg::*;
  `include "assert_macros.svh"

  rpe_push_t push;
  logic      queue_full;

  rpe_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_frame_byte   (in_frame_byte),
    .in_end_of_frame (in_end_of_frame),
    .queue_full      (queue_full),
    .push            (push)
  );

  rpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (queue_full),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_payload_byte    (out_payload_byte),
    .out_last_of_payload (out_last_of_payload),
    .out_truncated       (out_truncated)
  );

  `RPE_ASSERT_NEVER(a_no_push_when_full, clk, rst_n, push.valid && queue_full, "push into full queue")
  `RPE_ASSERT(a_push_needs_accept, clk, rst_n, push.valid |-> (in_valid && !in_stall), "word without accepted byte")
  `RPE_ASSERT(a_trunc_is_last, clk, rst_n, (out_valid && out_truncated) |-> out_last_of_payload, "truncated word not last")

endmodule

[verif/rtp_payload_checker.sv]
// checker for the rtp payload extractor: tracks frame headers, predicts payload words, compares
`timescale 1ns / 100ps
module rtp_payload_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_frame_byte,
  input  logic       in_end_of_frame,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_payload_byte,
  input  logic       out_last_of_payload,
  input  logic       out_truncated,
  output int         pending_words,
  output int         error_count
);
  import rpe_pkg::*;

  logic [6:0]  byte_offset;
  logic        frame_ok;
  logic [15:0] udp_length;
  logic [3:0]  csrc_count;
  logic [15:0] payload_left;
  rpe_word_t   expected_payload[$];

  initial begin
    error_count = 0;
    pending_words = 0;
  end

  task automatic start_frame();
    byte_offset  = '0;
    frame_ok     = 1'b1;
    udp_length   = '0;
    csrc_count   = '0;
    payload_left = '0;
  endtask

  task automatic track_frame_byte(input logic [7:0] b, input logic eof);
    logic [6:0]  off;
    logic [15:0] hdr_len;
    rpe_word_t   w;
    off = byte_offset;
    if (frame_ok) begin
      if (off == ETH_TYPE_HI_POS && b != ETH_TYPE_HI) begin
        frame_ok = 1'b0;
      end else if (off == ETH_TYPE_LO_POS && b != ETH_TYPE_LO) begin
        frame_ok = 1'b0;
      end else if (off == IP_PROTO_POS && b != PROTO_UDP) begin
        frame_ok = 1'b0;
      end else if (off == UDP_LEN_HI_POS) begin
        udp_length = {b, 8'h00};
      end else if (off == UDP_LEN_LO_POS) begin
        udp_length[7:0] = b;
      end else if (off == RTP_FIRST_POS) begin
        if ((b & VERSION_MASK) != VERSION_TWO) begin
          frame_ok = 1'b0;
        end else begin
          csrc_count = b[3:0];
          hdr_len = HDR_FIXED_BYTES + {10'd0, csrc_count, 2'b00};
          if (udp_length <= hdr_len) frame_ok = 1'b0;
          else payload_left = udp_length - hdr_len;
        end
      end else if (off > RTP_FIRST_POS &&
                   int'(off) >= int'(PAYLOAD_BASE_POS) + 4 * int'(csrc_count) &&
                   payload_left != 16'd0) begin
        payload_left = payload_left - 16'd1;
        w.payload_byte    = b;
        w.last_of_payload = (payload_left == 16'd0) || eof;
        w.truncated       = eof && (payload_left != 16'd0);
        expected_payload.push_back(w);
      end
    end
    if (eof) start_frame();
    else if (off != OFFSET_MAX) byte_offset = off + 7'd1;
  endtask

  always @(posedge clk) begin : watch
    rpe_word_t exp_word;
    if (!rst_n) begin
      start_frame();
      expected_payload.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_payload.size() == 0) begin
          $error("output word with no expected word pending: byte %0h", out_payload_byte);
          error_count++;
        end else begin
          exp_word = expected_payload.pop_front();
          if (out_payload_byte !== exp_word.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h",
                   exp_word.payload_byte, out_payload_byte);
            error_count++;
          end
          if (out_last_of_payload !== exp_word.last_of_payload) begin
            $error("last_of_payload: expected %0b, got %0b",
                   exp_word.last_of_payload, out_last_of_payload);
            error_count++;
          end
          if (out_truncated !== exp_word.truncated) begin
            $error("truncated: expected %0b, got %0b",
                   exp_word.truncated, out_truncated);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) track_frame_byte(in_frame_byte, in_end_of_frame);
    end
    pending_words <= expected_payload.size();
  end

endmodule

[verif/tb_rtp_payload_extractor.sv]
// testbench top for the rtp payload extractor: frame stimulus, idling phases and verdict
`timescale 1ns / 100ps
module tb_rtp_payload_extractor;
  import rpe_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_frame_byte;
  logic       in_end_of_frame;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_payload_byte;
  logic       out_last_of_payload;
  logic       out_truncated;

  int         pending_words;
  int         error_count;
  int         send_idle_pct;
  int         stall_pct;
  int         sent_bytes;
  logic [7:0] frame_q[$];

  rtp_payload_extractor i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_frame_byte       (in_frame_byte),
    .in_end_of_frame     (in_end_of_frame),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_payload_byte    (out_payload_byte),
    .out_last_of_payload (out_last_of_payload),
    .out_truncated       (out_truncated)
  );

  rtp_payload_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_frame_byte       (in_frame_byte),
    .in_end_of_frame     (in_end_of_frame),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_payload_byte    (out_payload_byte),
    .out_last_of_payload (out_last_of_payload),
    .out_truncated       (out_truncated),
    .pending_words       (pending_words),
    .error_count         (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_frame_byte   <= b;
    in_end_of_frame <= eof;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  task automatic set_udp_length(input logic [15:0] udp);
    frame_q[UDP_LEN_HI_POS] = udp[15:8];
    frame_q[UDP_LEN_LO_POS] = udp[7:0];
  endtask

  task automatic cut_frame(input int len);
    while (frame_q.size() > len) void'(frame_q.pop_back());
  endtask

  task automatic build_rtp(input int cc, input int plen, input logic [15:0] udp, input int pad);
    int total;
    total = int'(PAYLOAD_BASE_POS) + 4 * cc + plen + pad;
    frame_q.delete();
    repeat (total) frame_q.push_back(8'($urandom));
    frame_q[ETH_TYPE_HI_POS] = ETH_TYPE_HI;
    frame_q[ETH_TYPE_LO_POS] = ETH_TYPE_LO;
    frame_q[IP_PROTO_POS]    = PROTO_UDP;
    set_udp_length(udp);
    frame_q[RTP_FIRST_POS] = VERSION_TWO | {2'b00, 2'($urandom), 4'(cc)};
  endtask

  task automatic random_frame();
    int         kind;
    int         cc;
    int         plen;
    int         hdr;
    logic [7:0] bad;
    logic [1:0] ver;
    kind = $urandom_range(99);
    cc   = $urandom_range(1) ? 0 : $urandom_range(15);
    plen = $urandom_range(9) ? $urandom_range(1, 12) : $urandom_range(13, 80);
    hdr  = int'(HDR_FIXED_BYTES) + 4 * cc;
    build_rtp(cc, plen, 16'(hdr + plen), ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0);
    if (kind < 50) begin
    end else if (kind < 62) begin
      // frame may end early, sometimes with a huge udp length
      if ($urandom_range(1)) set_udp_length(16'($urandom_range(hdr + plen, 65535)));
      cut_frame($urandom_range(1, frame_q.size()));
    end else if (kind < 68) begin
      set_udp_length(16'($urandom_range(0, hdr)));
    end else if (kind < 85) begin
      bad = 8'($urandom);
      case ($urandom_range(3))
        0: begin
          if (bad == ETH_TYPE_HI) bad ^= 8'h01;
          frame_q[ETH_TYPE_HI_POS] = bad;
        end
        1: begin
          if (bad == ETH_TYPE_LO) bad ^= 8'h01;
          frame_q[ETH_TYPE_LO_POS] = bad;
        end
        2: begin
          if (bad == PROTO_UDP) bad ^= 8'h01;
          frame_q[IP_PROTO_POS] = bad;
        end
        default: begin
          ver = 2'($urandom_range(2));
          if (ver == 2'd2) ver = 2'd3;
          frame_q[RTP_FIRST_POS][7:6] = ver;
        end
      endcase
    end else begin
      frame_q.delete();
      repeat ($urandom_range(1, 70)) frame_q.push_back(8'($urandom));
    end
    send_frame();
  endtask

  initial begin
    int target;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_frame_byte   <= 8'h00;
    in_end_of_frame <= 1'b0;
    out_stall       <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    sent_bytes    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // shortest payload, ends exactly on its last byte
    build_rtp(0, 1, 16'd21, 0);
    send_frame();
    // most csrc words, trailing padding
    build_rtp(15, 2, 16'd82, 3);
    send_frame();
    // padding and extension bits set
    build_rtp(0, 4, 16'd24, 0);
    frame_q[RTP_FIRST_POS] = VERSION_TWO | 8'h30;
    send_frame();
    build_rtp(0, 3, 16'd23, 0);
    frame_q[ETH_TYPE_HI_POS] = 8'h86;
    send_frame();
    build_rtp(0, 3, 16'd23, 0);
    frame_q[ETH_TYPE_LO_POS] = 8'hdd;
    send_frame();
    build_rtp(0, 3, 16'd23, 0);
    frame_q[IP_PROTO_POS] = 8'd6;
    send_frame();
    for (int v = 0; v < 4; v++) begin
      if (v != 2) begin
        build_rtp(1, 3, 16'd27, 0);
        frame_q[RTP_FIRST_POS][7:6] = 2'(v);
        send_frame();
      end
    end
    // udp length equal to header, and zero
    build_rtp(2, 0, 16'd28, 4);
    send_frame();
    build_rtp(0, 0, 16'h0000, 2);
    send_frame();
    // end inside the headers
    build_rtp(0, 5, 16'd25, 0);
    cut_frame(30);
    send_frame();
    // end inside the payload
    build_rtp(0, 6, 16'hffff, 0);
    send_frame();
    // long frame past the offset limit
    build_rtp(15, 70, 16'd150, 5);
    send_frame();
    frame_q.delete();
    frame_q.push_back(8'hff);
    send_frame();
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 88;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 88;
        end
        default: begin
          send_idle_pct = 23;
          stall_pct     = 23;
        end
      endcase
      target = sent_bytes + 140;
      while (sent_bytes < target) begin
        if ($urandom_range(9) == 0) wait_drained();
        random_frame();
      end
      wait_drained();
    end

    repeat (QUEUE_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
